@@ design/tbc_pkg.sv @@
// Shared types and codes for the transceiver bring-up controller.
package tbc_pkg;

    typedef enum logic [1:0] {
        ST_NOT_INSTALLED = 2'd0,
        ST_DEPENDENCY    = 2'd1,
        ST_OFFLINE       = 2'd2,
        ST_ENABLED       = 2'd3
    } op_state_t;

    typedef enum logic [3:0] {
        FUNC_SWACT       = 4'd0,
        FUNC_RAMP_READY  = 4'd1,
        FUNC_REPORT      = 4'd2,
        FUNC_ATTR_REPLY  = 4'd3,
        FUNC_CONN_ACK    = 4'd4,
        FUNC_CONN_NACK   = 4'd5,
        FUNC_START_ACK   = 4'd6,
        FUNC_START_NACK  = 4'd7,
        FUNC_LINK_DOWN   = 4'd8
    } func_t;

    localparam logic [2:0] AV_NOT_INSTALLED = 3'd0;
    localparam logic [2:0] AV_POWER_OFF     = 3'd1;
    localparam logic [2:0] AV_DEPENDENCY    = 3'd2;
    localparam logic [2:0] AV_OFFLINE       = 3'd3;
    localparam logic [2:0] AV_OK            = 3'd4;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAIT_SW_ACT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REQ_FEATURE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_OFFLINE  = 2'd2;

    typedef struct packed {
        logic wait_sw_act;
        logic req_feature;
        logic no_offline;
    } cfg_t;

    typedef struct packed {
        logic swact_seen;
        logic attr_requested;
        logic attr_replied;
        logic unlock_requested;
        logic connect_requested;
        logic connect_acked;
        logic start_requested;
    } prog_t;

    typedef struct packed {
        func_t      func;
        logic       rep_operational_enabled;
        logic [2:0] rep_availability;
        logic       admin_unlocked;
        logic       ramp_waiting;
    } item_t;

    typedef struct packed {
        op_state_t new_state;
        logic      send_get_attr;
        logic      attr_with_features;
        logic      send_admin_unlock;
        logic      send_link_connect;
        logic      send_opstart;
        logic      notify_enabled;
        logic      notify_disabled;
        logic      drop_link;
    } result_t;

endpackage

@@ design/tbc_step.sv @@
// Event decision logic: one event against the current state and progress flags.
module tbc_step (
    input  tbc_pkg::cfg_t      cfg,
    input  tbc_pkg::op_state_t state,
    input  tbc_pkg::prog_t     prog,
    input  tbc_pkg::item_t     item,
    output tbc_pkg::op_state_t state_next,
    output tbc_pkg::prog_t     prog_next,
    output tbc_pkg::result_t   result
);
    import tbc_pkg::*;

    typedef struct packed {
        prog_t prog;
        logic  get_attr;
        logic  feat;
        logic  unlock;
        logic  conn;
        logic  start;
    } loop_t;

    typedef struct packed {
        op_state_t st;
        loop_t     lp;
        logic      en;
    } enter_t;

    // Request sequencer: issues whatever request the progress flags call for next.
    function automatic loop_t run_loop(prog_t p, logic allow, logic admin, logic ramp,
                                       cfg_t c);
        loop_t r;
        r = '0;
        r.prog = p;
        if (!ramp && !(c.wait_sw_act && !p.swact_seen)) begin
            if (!p.attr_requested && !p.attr_replied) begin
                r.get_attr = 1'b1;
                r.feat = c.req_feature;
                r.prog.attr_requested = 1'b1;
            end
            if (p.attr_replied && !admin && !p.unlock_requested) begin
                r.unlock = 1'b1;
                r.prog.unlock_requested = 1'b1;
            end
            if (allow && admin && !p.connect_requested && !p.connect_acked) begin
                r.conn = 1'b1;
                r.prog.connect_requested = 1'b1;
            end
            if (allow && admin && p.connect_acked && !p.start_requested) begin
                r.start = 1'b1;
                r.prog.start_requested = 1'b1;
            end
        end
        return r;
    endfunction

    // On-enter actions of a state change.
    function automatic enter_t enter_state(op_state_t s, prog_t p, logic admin, logic ramp,
                                           cfg_t c);
        enter_t r;
        r = '0;
        r.st = s;
        r.lp.prog = p;
        case (s)
            ST_NOT_INSTALLED: begin
                r.lp.prog = '0;
            end
            ST_DEPENDENCY: begin
                if (c.no_offline) begin
                    r.st = ST_OFFLINE;
                    r.lp = run_loop(p, 1'b1, admin, ramp, c);
                end else begin
                    r.lp = run_loop(p, 1'b0, admin, ramp, c);
                end
            end
            ST_OFFLINE: begin
                r.lp = run_loop(p, 1'b1, admin, ramp, c);
            end
            default: begin
                r.lp.prog = '0;
                r.lp.prog.swact_seen = p.swact_seen;
                r.en = 1'b1;
            end
        endcase
        return r;
    endfunction

    prog_t     p_pre;
    logic      do_enter;
    logic      do_loop;
    logic      loop_allow;
    op_state_t target;
    logic      dis;
    logic      drop;
    logic      wait_state;
    logic      av_gone;
    logic      av_ready;
    enter_t    ent;
    loop_t     lp;
    loop_t     act;
    logic      en;

    always_comb begin
        p_pre      = prog;
        do_enter   = 1'b0;
        do_loop    = 1'b0;
        loop_allow = (state == ST_OFFLINE);
        target     = ST_NOT_INSTALLED;
        dis        = 1'b0;
        drop       = 1'b0;
        wait_state = (state == ST_DEPENDENCY) || (state == ST_OFFLINE);
        av_gone    = (item.rep_availability == AV_NOT_INSTALLED) ||
                     (item.rep_availability == AV_POWER_OFF);
        av_ready   = (item.rep_availability == AV_OFFLINE) ||
                     (item.rep_availability == AV_OK);

        case (item.func)
            FUNC_SWACT: begin
                if (state != ST_ENABLED) begin
                    p_pre.swact_seen = 1'b1;
                end
                do_loop = wait_state;
            end
            FUNC_RAMP_READY: begin
                do_loop = wait_state;
            end
            FUNC_REPORT: begin
                if (state == ST_ENABLED) begin
                    if (!item.rep_operational_enabled) begin
                        if (av_gone) begin
                            dis = 1'b1; do_enter = 1'b1; target = ST_NOT_INSTALLED;
                        end else if (item.rep_availability == AV_DEPENDENCY) begin
                            dis = 1'b1; do_enter = 1'b1; target = ST_DEPENDENCY;
                        end else if (av_ready) begin
                            dis = 1'b1; do_enter = 1'b1; target = ST_OFFLINE;
                        end
                    end
                end else if (item.rep_operational_enabled) begin
                    do_enter = 1'b1;
                    target   = ST_ENABLED;
                end else if (state == ST_NOT_INSTALLED) begin
                    if (item.rep_availability == AV_DEPENDENCY) begin
                        do_enter = 1'b1; target = ST_DEPENDENCY;
                    end else if (av_ready) begin
                        do_enter = 1'b1; target = ST_OFFLINE;
                    end
                end else if (av_gone) begin
                    do_enter = 1'b1;
                    target   = ST_NOT_INSTALLED;
                end else if (item.rep_availability == AV_DEPENDENCY) begin
                    if (state == ST_OFFLINE && !cfg.no_offline) begin
                        do_enter = 1'b1; target = ST_DEPENDENCY;
                    end else begin
                        do_loop = 1'b1;
                    end
                end else if (av_ready) begin
                    if (state == ST_DEPENDENCY) begin
                        do_enter = 1'b1; target = ST_OFFLINE;
                    end else begin
                        do_loop = 1'b1; loop_allow = 1'b1;
                    end
                end
            end
            FUNC_ATTR_REPLY: begin
                if (wait_state) begin
                    p_pre.attr_replied   = 1'b1;
                    p_pre.attr_requested = 1'b0;
                    do_loop = 1'b1;
                end
            end
            FUNC_CONN_ACK: begin
                if (wait_state) begin
                    p_pre.connect_acked     = 1'b1;
                    p_pre.connect_requested = 1'b0;
                    do_loop = 1'b1;
                end
            end
            FUNC_CONN_NACK: begin
                drop = wait_state;
            end
            FUNC_START_ACK, FUNC_START_NACK: begin
                p_pre.start_requested = 1'b0;
            end
            FUNC_LINK_DOWN: begin
                if (state != ST_NOT_INSTALLED) begin
                    dis = (state == ST_ENABLED);
                    do_enter = 1'b1;
                    target = ST_NOT_INSTALLED;
                end
            end
            default: begin
            end
        endcase

        ent = enter_state(target, p_pre, item.admin_unlocked, item.ramp_waiting, cfg);
        lp  = run_loop(p_pre, loop_allow, item.admin_unlocked, item.ramp_waiting, cfg);

        en = 1'b0;
        if (do_enter) begin
            state_next = ent.st;
            act        = ent.lp;
            en         = ent.en;
        end else if (do_loop) begin
            state_next = state;
            act        = lp;
        end else begin
            state_next = state;
            act        = '0;
            act.prog   = p_pre;
        end
        prog_next = act.prog;

        result.new_state          = state_next;
        result.send_get_attr      = act.get_attr;
        result.attr_with_features = act.feat;
        result.send_admin_unlock  = act.unlock;
        result.send_link_connect  = act.conn;
        result.send_opstart       = act.start;
        result.notify_enabled     = en;
        result.notify_disabled    = dis;
        result.drop_link          = drop;
    end

endmodule

@@ design/transceiver_bringup_controller.sv @@
// Top level of the transceiver bring-up controller: stream ports, registers, state.
// A taken event waits in the input register; its result is then registered onto m_tdata.
// Throughput: one event per cycle; the input stalls only while both registers are full
// and the result is held. State and progress flags update as the result register loads.
// Reset (aresetn low, synchronous) empties both registers, clears all configuration bits,
// and returns the object to not installed with every progress flag cleared.
module transceiver_bringup_controller (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  logic [tbc_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  logic [0:0]                         cfg_wr_data,
    // Event channel.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata, low bit up: rep_operational_enabled[0], rep_availability[3:1],
    // admin_unlocked[4], ramp_waiting[5], zero padding[7:6].
    input  logic [7:0]                         s_tdata,
    // s_tuser: func[3:0].
    input  logic [3:0]                         s_tuser,
    // Result channel.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata, low bit up: new_state[1:0], send_get_attr[2], attr_with_features[3],
    // send_admin_unlock[4], send_link_connect[5], send_opstart[6], notify_enabled[7],
    // notify_disabled[8], drop_link[9], zero padding[15:10].
    output logic [15:0]                        m_tdata
);
    import tbc_pkg::*;

    cfg_t      cfg_reg;
    item_t     item_reg;
    logic      in_valid_reg;
    result_t   result_reg;
    logic      out_valid_reg;
    op_state_t state_reg;
    prog_t     prog_reg;

    op_state_t state_next;
    prog_t     prog_next;
    result_t   result_next;
    logic      advance;
    logic      in_take;

    // Write configuration bits only with no transaction in flight; the block does not check.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_WAIT_SW_ACT: cfg_reg.wait_sw_act <= cfg_wr_data[0];
                CFG_REQ_FEATURE: cfg_reg.req_feature <= cfg_wr_data[0];
                CFG_NO_OFFLINE:  cfg_reg.no_offline  <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // The held event moves on whenever the result register is empty or being drained,
    // so a new event can enter in the same cycle and the pipeline never bubbles.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            item_reg.func                    <= func_t'(s_tuser);
            item_reg.rep_operational_enabled <= s_tdata[0];
            item_reg.rep_availability        <= s_tdata[3:1];
            item_reg.admin_unlocked          <= s_tdata[4];
            item_reg.ramp_waiting            <= s_tdata[5];
        end
    end

    tbc_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .prog       (prog_reg),
        .item       (item_reg),
        .state_next (state_next),
        .prog_next  (prog_next),
        .result     (result_next)
    );

    // The state commits together with the result, so the next event sees it at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_NOT_INSTALLED;
            prog_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            state_reg     <= state_next;
            prog_reg      <= prog_next;
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       result_reg.drop_link,
                       result_reg.notify_disabled,
                       result_reg.notify_enabled,
                       result_reg.send_opstart,
                       result_reg.send_link_connect,
                       result_reg.send_admin_unlock,
                       result_reg.attr_with_features,
                       result_reg.send_get_attr,
                       result_reg.new_state};

`ifndef SYNTHESIS
    // The input side only stalls while both registers are full and the result is held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a held result");

    // Enabled means every request flag was cleared on entry and none was raised since.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ENABLED) |-> (prog_reg.attr_requested == 1'b0 &&
            prog_reg.attr_replied == 1'b0 && prog_reg.unlock_requested == 1'b0 &&
            prog_reg.connect_requested == 1'b0 && prog_reg.connect_acked == 1'b0 &&
            prog_reg.start_requested == 1'b0))
        else $error("progress flags set while enabled");

    // The feature attribute only rides along with a get-attributes request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && result_reg.attr_with_features) |-> result_reg.send_get_attr)
        else $error("feature attribute without get-attributes request");

    // An enable notification always reports the enabled state and no disable.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && result_reg.notify_enabled) |->
            (result_reg.new_state == ST_ENABLED && !result_reg.notify_disabled))
        else $error("enable notification in wrong state");

    // A result that is not taken stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(result_reg)))
        else $error("held result changed");
`endif

endmodule
